// ===== rtl/core/esd_pkg.sv =====
// shared types, character codes and constants of the escape sequence decoder
package esd_pkg;

    // field widths
    localparam int unsigned CP_W     = 21;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 4;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_HEX_EXPECTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID_ESC  = 2'd2;

    // positions taken by the fixed-width unicode forms
    localparam logic [COUNT_W-1:0] U_SHORT_DIGITS = 4'd4;
    localparam logic [COUNT_W-1:0] U_LONG_DIGITS  = 4'd8;

    // character codes
    localparam logic [CP_W-1:0] CH_BACKSLASH = 21'h00005C;
    localparam logic [CP_W-1:0] CH_0         = 21'h000030;
    localparam logic [CP_W-1:0] CH_7         = 21'h000037;
    localparam logic [CP_W-1:0] CH_9         = 21'h000039;
    localparam logic [CP_W-1:0] CH_UP_A      = 21'h000041;
    localparam logic [CP_W-1:0] CH_UP_D      = 21'h000044;
    localparam logic [CP_W-1:0] CH_UP_F      = 21'h000046;
    localparam logic [CP_W-1:0] CH_UP_U      = 21'h000055;
    localparam logic [CP_W-1:0] CH_UP_X      = 21'h000058;
    localparam logic [CP_W-1:0] CH_LO_A      = 21'h000061;
    localparam logic [CP_W-1:0] CH_LO_B      = 21'h000062;
    localparam logic [CP_W-1:0] CH_LO_D      = 21'h000064;
    localparam logic [CP_W-1:0] CH_LO_F      = 21'h000066;
    localparam logic [CP_W-1:0] CH_LO_N      = 21'h00006E;
    localparam logic [CP_W-1:0] CH_LO_R      = 21'h000072;
    localparam logic [CP_W-1:0] CH_LO_T      = 21'h000074;
    localparam logic [CP_W-1:0] CH_LO_U      = 21'h000075;
    localparam logic [CP_W-1:0] CH_LO_V      = 21'h000076;
    localparam logic [CP_W-1:0] CH_LO_X      = 21'h000078;

    // control codes of the single-letter escapes
    localparam logic [CP_W-1:0] CTRL_BEL = 21'd7;
    localparam logic [CP_W-1:0] CTRL_BS  = 21'd8;
    localparam logic [CP_W-1:0] CTRL_HT  = 21'd9;
    localparam logic [CP_W-1:0] CTRL_LF  = 21'd10;
    localparam logic [CP_W-1:0] CTRL_VT  = 21'd11;
    localparam logic [CP_W-1:0] CTRL_FF  = 21'd12;
    localparam logic [CP_W-1:0] CTRL_CR  = 21'd13;

    // parser modes
    typedef enum logic [2:0] {
        MODE_START,
        MODE_SELECT,
        MODE_HEX,
        MODE_DEC,
        MODE_OCT,
        MODE_FIXED,
        MODE_DONE
    } parse_mode_t;

    // classification of one character
    typedef struct packed {
        logic            backslash;
        logic            is_hex;
        logic            is_dec;
        logic            is_oct;
        logic            hex_mode;
        logic            dec_mode;
        logic            u_short;
        logic            u_long;
        logic [3:0]      digit;
        logic [CP_W-1:0] single_val;
    } char_class_t;

    // result handed to the output register
    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } esd_result_t;

endpackage

// ===== rtl/core/esd_classify.sv =====
// character classifier: digit values, mode letters and single-letter mapping
module esd_classify
(
    input  logic [esd_pkg::CP_W-1:0] code_point,
    output esd_pkg::char_class_t     cls
);

    logic [esd_pkg::CP_W-1:0] cls_single;

    // digit ranges and their values
    always_comb
    begin
        cls = '0;
        cls.backslash = (code_point == esd_pkg::CH_BACKSLASH);
        cls.hex_mode  = (code_point == esd_pkg::CH_LO_X) || (code_point == esd_pkg::CH_UP_X);
        cls.dec_mode  = (code_point == esd_pkg::CH_LO_D) || (code_point == esd_pkg::CH_UP_D);
        cls.u_short   = (code_point == esd_pkg::CH_LO_U);
        cls.u_long    = (code_point == esd_pkg::CH_UP_U);
        cls.is_oct    = code_point inside {[esd_pkg::CH_0 : esd_pkg::CH_7]};
        cls.single_val = cls_single;
        if (code_point inside {[esd_pkg::CH_0 : esd_pkg::CH_9]})
        begin
            cls.is_dec = 1'b1;
            cls.is_hex = 1'b1;
            cls.digit  = code_point[3:0];
        end
        else if (code_point inside {[esd_pkg::CH_LO_A : esd_pkg::CH_LO_F],
                                    [esd_pkg::CH_UP_A : esd_pkg::CH_UP_F]})
        begin
            // low nibble of a..f and A..F runs 1..6
            cls.is_hex = 1'b1;
            cls.digit  = code_point[3:0] + 4'd9;
        end
    end

    // single-letter escapes map to control codes, anything else to itself
    always_comb
    begin
        case (code_point)
            esd_pkg::CH_LO_A: cls_single = esd_pkg::CTRL_BEL;
            esd_pkg::CH_LO_B: cls_single = esd_pkg::CTRL_BS;
            esd_pkg::CH_LO_F: cls_single = esd_pkg::CTRL_FF;
            esd_pkg::CH_LO_N: cls_single = esd_pkg::CTRL_LF;
            esd_pkg::CH_LO_R: cls_single = esd_pkg::CTRL_CR;
            esd_pkg::CH_LO_T: cls_single = esd_pkg::CTRL_HT;
            esd_pkg::CH_LO_V: cls_single = esd_pkg::CTRL_VT;
            default:          cls_single = code_point;
        endcase
    end

endmodule

// ===== rtl/core/esd_parser.sv =====
// token parser: mode, accumulator and position state with one-word update
module esd_parser
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   last_char,
    input  esd_pkg::char_class_t   cls,
    output esd_pkg::esd_result_t   result
);

    esd_pkg::parse_mode_t              mode_reg, mode_next;
    logic [esd_pkg::VALUE_W-1:0]       acc_reg, acc_next;
    logic [esd_pkg::COUNT_W-1:0]       left_reg, left_next, left_dec;
    logic                              trail_reg, trail_next;
    logic                              select;
    logic [esd_pkg::VALUE_W-1:0]       acc_dec;

    // decimal step: acc * 10 + digit as two shifts and two adds
    assign acc_dec = {acc_reg[esd_pkg::VALUE_W-4:0], 3'b000}
                   + {acc_reg[esd_pkg::VALUE_W-2:0], 1'b0}
                   + {{(esd_pkg::VALUE_W-4){1'b0}}, cls.digit};

    assign left_dec = (left_reg != '0) ? left_reg - 4'd1 : left_reg;

    // the mode letter is read right after the backslash, or first if none
    assign select = (mode_reg == esd_pkg::MODE_SELECT)
                 || ((mode_reg == esd_pkg::MODE_START) && !cls.backslash);

    // next state for one word
    always_comb
    begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        trail_next = trail_reg;
        if (select)
        begin
            acc_next = '0;
            if (cls.hex_mode)
            begin
                mode_next = esd_pkg::MODE_HEX;
            end
            else if (cls.dec_mode)
            begin
                mode_next = esd_pkg::MODE_DEC;
            end
            else if (cls.is_oct)
            begin
                acc_next  = {{(esd_pkg::VALUE_W-3){1'b0}}, cls.digit[2:0]};
                mode_next = esd_pkg::MODE_OCT;
            end
            else if (cls.u_short)
            begin
                left_next = esd_pkg::U_SHORT_DIGITS;
                mode_next = esd_pkg::MODE_FIXED;
            end
            else if (cls.u_long)
            begin
                left_next = esd_pkg::U_LONG_DIGITS;
                mode_next = esd_pkg::MODE_FIXED;
            end
            else
            begin
                acc_next  = {{(esd_pkg::VALUE_W-esd_pkg::CP_W){1'b0}}, cls.single_val};
                mode_next = esd_pkg::MODE_DONE;
            end
        end
        else
        begin
            case (mode_reg)
                esd_pkg::MODE_START:
                begin
                    mode_next = esd_pkg::MODE_SELECT;
                end
                esd_pkg::MODE_HEX:
                begin
                    if (cls.is_hex)
                    begin
                        acc_next = {acc_reg[esd_pkg::VALUE_W-5:0], cls.digit};
                    end
                    else
                    begin
                        trail_next = 1'b1;
                        mode_next  = esd_pkg::MODE_DONE;
                    end
                end
                esd_pkg::MODE_DEC:
                begin
                    if (cls.is_dec)
                    begin
                        acc_next = acc_dec;
                    end
                    else
                    begin
                        trail_next = 1'b1;
                        mode_next  = esd_pkg::MODE_DONE;
                    end
                end
                esd_pkg::MODE_OCT:
                begin
                    if (cls.is_oct)
                    begin
                        acc_next = {acc_reg[esd_pkg::VALUE_W-4:0], cls.digit[2:0]};
                    end
                    else
                    begin
                        trail_next = 1'b1;
                        mode_next  = esd_pkg::MODE_DONE;
                    end
                end
                esd_pkg::MODE_FIXED:
                begin
                    // a non-hex character still takes a position
                    if (cls.is_hex)
                    begin
                        acc_next = {acc_reg[esd_pkg::VALUE_W-5:0], cls.digit};
                    end
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        mode_next = esd_pkg::MODE_DONE;
                    end
                end
                default:
                begin
                    trail_next = 1'b1;
                    mode_next  = esd_pkg::MODE_DONE;
                end
            endcase
        end
    end

    // result of the token when this word is its last
    always_comb
    begin
        if ((mode_next == esd_pkg::MODE_FIXED) && (left_next != '0))
        begin
            result.status = esd_pkg::STATUS_HEX_EXPECTED;
            result.value  = '0;
        end
        else if (trail_next)
        begin
            result.status = esd_pkg::STATUS_INVALID_ESC;
            result.value  = '0;
        end
        else
        begin
            result.status = esd_pkg::STATUS_OK;
            result.value  = acc_next;
        end
    end

    // state registers, back to start of token after the last word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= esd_pkg::MODE_START;
            acc_reg   <= '0;
            left_reg  <= '0;
            trail_reg <= 1'b0;
        end
        else if (step)
        begin
            if (last_char)
            begin
                mode_reg  <= esd_pkg::MODE_START;
                acc_reg   <= '0;
                left_reg  <= '0;
                trail_reg <= 1'b0;
            end
            else
            begin
                mode_reg  <= mode_next;
                acc_reg   <= acc_next;
                left_reg  <= left_next;
                trail_reg <= trail_next;
            end
        end
    end

endmodule

// ===== rtl/core/escape_sequence_decoder.sv =====
// escape sequence decoder top level: input register, parser and result register
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------
//  input   | in_valid  | in_stall  | code_point, last_char
//  output  | out_valid | out_stall | escape_value, status
//
// one word per cycle is taken unless a word that ends a token waits for a
// busy result register; a result passes the input register, then the result
// register, before it is valid. the throughput is set by the parser update of
// mode and accumulator. reset clears the parser to start of token and empties
// both registers. a stalled result holds only words that end a token; other
// words keep flowing through the parser.
module escape_sequence_decoder
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [esd_pkg::CP_W-1:0]      code_point,
    input  logic                          last_char,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [esd_pkg::VALUE_W-1:0]   escape_value,
    output logic [esd_pkg::STATUS_W-1:0]  status
);

    logic                           word_vld_reg;
    logic [esd_pkg::CP_W-1:0]       cp_reg;
    logic                           last_reg;
    logic                           res_vld_reg;
    esd_pkg::esd_result_t           res_reg;
    esd_pkg::char_class_t           cls;
    esd_pkg::esd_result_t           result;
    logic                           res_free;
    logic                           step;
    logic                           load;

    // handshake between the two registers
    assign res_free = !res_vld_reg || !out_stall;
    assign step     = word_vld_reg && (!last_reg || res_free);
    assign load     = !word_vld_reg || step;
    assign in_stall = !load;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_vld_reg <= 1'b0;
        end
        else if (load)
        begin
            word_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            cp_reg   <= code_point;
            last_reg <= last_char;
        end
    end

    esd_classify u_classify
    (
        .code_point (cp_reg),
        .cls        (cls)
    );

    esd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .last_char (last_reg),
        .cls       (cls),
        .result    (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (res_free)
        begin
            res_vld_reg <= step && last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_free && step && last_reg)
        begin
            res_reg <= result;
        end
    end

    assign out_valid    = res_vld_reg;
    assign escape_value = res_reg.value;
    assign status       = res_reg.status;

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench of the escape sequence decoder with random token streams
`timescale 1ns / 100ps

module tb_top;

    import esd_pkg::*;

    localparam int unsigned ITEM_TARGET = 1700;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned DRAIN_EVERY = 120;
    localparam int unsigned TAIL_CYCLES = 8;

    // one input word waiting to be driven
    typedef struct {
        logic [CP_W-1:0] cp;
        logic            last;
        logic            drain;
    } char_word_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [CP_W-1:0]     code_point = '0;
    logic                last_char = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [VALUE_W-1:0]  escape_value;
    logic [STATUS_W-1:0] status;

    char_word_t   char_q[$];
    esd_result_t  decoded_q[$];
    bit           drain_next = 1'b0;

    // decoder state as predicted
    parse_mode_t        pred_mode = MODE_START;
    logic [VALUE_W-1:0] pred_acc = '0;
    logic [COUNT_W-1:0] pred_left = '0;
    logic               pred_trail = 1'b0;

    int unsigned  mismatch_cnt = 0;
    int unsigned  cycle_cnt = 0;
    int unsigned  gap_left = 0;
    int unsigned  stall_left = 0;
    bit           send_burst = 1'b0;
    bit           sink_burst = 1'b0;
    char_word_t   next_word;
    esd_result_t  want;

    escape_sequence_decoder u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .code_point   (code_point),
        .last_char    (last_char),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .escape_value (escape_value),
        .status       (status)
    );

    always #5 clk = ~clk;

    // hex digit weight, or -1 for a non-hex character
    function automatic int hex_weight(logic [CP_W-1:0] c);
        if (c >= CH_0 && c <= CH_9)
        begin
            return int'(c - CH_0);
        end
        if (c >= CH_LO_A && c <= CH_LO_F)
        begin
            return int'(c - CH_LO_A) + 10;
        end
        if (c >= CH_UP_A && c <= CH_UP_F)
        begin
            return int'(c - CH_UP_A) + 10;
        end
        return -1;
    endfunction

    // control code of a single-letter escape, otherwise the character itself
    function automatic logic [VALUE_W-1:0] letter_code(logic [CP_W-1:0] c);
        case (c)
            CH_LO_A: return VALUE_W'(CTRL_BEL);
            CH_LO_B: return VALUE_W'(CTRL_BS);
            CH_LO_F: return VALUE_W'(CTRL_FF);
            CH_LO_N: return VALUE_W'(CTRL_LF);
            CH_LO_R: return VALUE_W'(CTRL_CR);
            CH_LO_T: return VALUE_W'(CTRL_HT);
            CH_LO_V: return VALUE_W'(CTRL_VT);
            default: return VALUE_W'(c);
        endcase
    endfunction

    // mode picked by the character after the backslash
    task automatic pick_mode(input logic [CP_W-1:0] c);
        pred_acc = '0;
        if (c == CH_LO_X || c == CH_UP_X)
        begin
            pred_mode = MODE_HEX;
        end
        else if (c == CH_LO_D || c == CH_UP_D)
        begin
            pred_mode = MODE_DEC;
        end
        else if (c >= CH_0 && c <= CH_7)
        begin
            pred_acc  = VALUE_W'(c - CH_0);
            pred_mode = MODE_OCT;
        end
        else if (c == CH_LO_U)
        begin
            pred_left = U_SHORT_DIGITS;
            pred_mode = MODE_FIXED;
        end
        else if (c == CH_UP_U)
        begin
            pred_left = U_LONG_DIGITS;
            pred_mode = MODE_FIXED;
        end
        else
        begin
            pred_acc  = letter_code(c);
            pred_mode = MODE_DONE;
        end
    endtask

    // advance the predicted parser by one accepted word
    task automatic decode_char(input logic [CP_W-1:0] c, input logic last);
        int          h;
        esd_result_t r;
        h = hex_weight(c);
        case (pred_mode)
            MODE_START:
            begin
                if (c == CH_BACKSLASH)
                    pred_mode = MODE_SELECT;
                else
                    pick_mode(c);
            end
            MODE_SELECT:
                pick_mode(c);
            MODE_HEX:
            begin
                if (h >= 0)
                    pred_acc = pred_acc * 32'd16 + VALUE_W'(h);
                else
                begin
                    pred_trail = 1'b1;
                    pred_mode  = MODE_DONE;
                end
            end
            MODE_DEC:
            begin
                if (c >= CH_0 && c <= CH_9)
                    pred_acc = pred_acc * 32'd10 + VALUE_W'(c - CH_0);
                else
                begin
                    pred_trail = 1'b1;
                    pred_mode  = MODE_DONE;
                end
            end
            MODE_OCT:
            begin
                if (c >= CH_0 && c <= CH_7)
                    pred_acc = pred_acc * 32'd8 + VALUE_W'(c - CH_0);
                else
                begin
                    pred_trail = 1'b1;
                    pred_mode  = MODE_DONE;
                end
            end
            MODE_FIXED:
            begin
                // a non-hex position is used up without touching the value
                if (h >= 0)
                    pred_acc = pred_acc * 32'd16 + VALUE_W'(h);
                if (pred_left != 0)
                    pred_left = pred_left - 1'b1;
                if (pred_left == 0)
                    pred_mode = MODE_DONE;
            end
            default:
            begin
                pred_trail = 1'b1;
                pred_mode  = MODE_DONE;
            end
        endcase

        if (last)
        begin
            // an unfinished unicode form wins over trailing characters
            if (pred_mode == MODE_FIXED && pred_left != 0)
            begin
                r.value  = '0;
                r.status = STATUS_HEX_EXPECTED;
            end
            else if (pred_trail)
            begin
                r.value  = '0;
                r.status = STATUS_INVALID_ESC;
            end
            else
            begin
                r.value  = pred_acc;
                r.status = STATUS_OK;
            end
            decoded_q.push_back(r);
            pred_mode  = MODE_START;
            pred_acc   = '0;
            pred_left  = '0;
            pred_trail = 1'b0;
        end
    endtask

    // idle length: mostly short, now and then long, none during a burst
    function automatic int unsigned idle_len(bit burst);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst || r < 65)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CP_W-1:0] rand_cp();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return CP_W'($urandom_range(32'h20, 32'h7E));
        if (r < 7)
            return CP_W'($urandom_range(0, 127));
        if (r < 9)
            return CP_W'($urandom_range(0, 1114111));
        return CP_W'($urandom());
    endfunction

    function automatic logic [CP_W-1:0] hex_char(int unsigned v, bit upper);
        if (v < 10)
            return CH_0 + CP_W'(v);
        return (upper ? CH_UP_A : CH_LO_A) + CP_W'(v - 10);
    endfunction

    task automatic add_char(input logic [CP_W-1:0] c, input logic last);
        char_word_t w;
        w.cp    = c;
        w.last  = last;
        w.drain = drain_next;
        char_q.push_back(w);
        drain_next = 1'b0;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(CP_W'(s[i]), i == s.len() - 1);
    endtask

    // one token: mostly well-formed escapes with random content, some noise
    task automatic add_random_token();
        logic [CP_W-1:0] tok[$];
        int unsigned     kind;
        int unsigned     n;
        int unsigned     pos;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                tok.push_back(rand_cp());
        end
        else
        begin
            if (kind < 11 || $urandom_range(0, 9) != 0)
                tok.push_back(CH_BACKSLASH);
            if (kind < 11)
            begin
                // lone backslash
            end
            else if (kind < 26)
            begin
                tok.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
                n = $urandom_range(0, 10);
                for (int i = 0; i < n; i++)
                    tok.push_back(hex_char($urandom_range(0, 15),
                                           1'($urandom_range(0, 1))));
            end
            else if (kind < 38)
            begin
                tok.push_back($urandom_range(0, 1) ? CH_LO_D : CH_UP_D);
                n = $urandom_range(0, 12);
                for (int i = 0; i < n; i++)
                    tok.push_back(CH_0 + CP_W'($urandom_range(0, 9)));
            end
            else if (kind < 50)
            begin
                n = $urandom_range(0, 11);
                for (int i = 0; i <= n; i++)
                    tok.push_back(CH_0 + CP_W'($urandom_range(0, 7)));
            end
            else if (kind < 78)
            begin
                tok.push_back(kind < 65 ? CH_LO_U : CH_UP_U);
                pos = (kind < 65) ? 4 : 8;
                // cut short now and then
                if ($urandom_range(0, 99) < 15)
                    pos = $urandom_range(0, pos - 1);
                for (int i = 0; i < pos; i++)
                begin
                    if ($urandom_range(0, 99) < 85)
                        tok.push_back(hex_char($urandom_range(0, 15),
                                               1'($urandom_range(0, 1))));
                    else
                        tok.push_back(rand_cp());
                end
            end
            else if (kind < 92 && $urandom_range(0, 9) < 6)
            begin
                case ($urandom_range(0, 6))
                    0: tok.push_back(CH_LO_A);
                    1: tok.push_back(CH_LO_B);
                    2: tok.push_back(CH_LO_F);
                    3: tok.push_back(CH_LO_N);
                    4: tok.push_back(CH_LO_R);
                    5: tok.push_back(CH_LO_T);
                    default: tok.push_back(CH_LO_V);
                endcase
            end
            else
            begin
                tok.push_back(rand_cp());
            end
            // trailing characters after the escape
            if ($urandom_range(0, 99) < 12)
            begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    tok.push_back(rand_cp());
            end
        end
        foreach (tok[i])
            add_char(tok[i], i == tok.size() - 1);
    endtask

    // driver: feeds queued words, holds a stalled word, idles at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            code_point <= '0;
            last_char  <= 1'b0;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                decode_char(code_point, last_char);
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (char_q.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (char_q[0].drain && decoded_q.size() != 0)
                begin
                    // hold off until every pending result is out
                    in_valid <= 1'b0;
                end
                else
                begin
                    next_word  = char_q.pop_front();
                    code_point <= next_word.cp;
                    last_char  <= next_word.last;
                    in_valid   <= 1'b1;
                    gap_left   <= idle_len(send_burst);
                    if ($urandom_range(0, 149) == 0)
                        send_burst <= !send_burst;
                end
            end
        end
    end

    // monitor: random stall, result compared with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (decoded_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result: value %h status %0d",
                                 escape_value, status);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (escape_value !== want.value || status !== want.status)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch: value %h status %0d, expected value %h status %0d",
                                     escape_value, status, want.value, want.status);
                    end
                end
            end
            if (stall_left != 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left <= idle_len(sink_burst);
                if ($urandom_range(0, 99) == 0)
                    sink_burst <= !sink_burst;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("** escape_sequence_decoder: FAILED **");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        int unsigned tokens;
        tokens = 0;

        // directed tokens
        add_text("\\");
        add_text("\\n");
        add_text("\\x");
        add_text("\\u12");
        add_text("\\uzA0f");
        add_text("7");
        add_text("\\q!");
        add_char(21'h1FFFFF, 1'b1);
        add_text("\\0");

        while (char_q.size() < ITEM_TARGET)
        begin
            tokens++;
            if (tokens % DRAIN_EVERY == 1)
                drain_next = 1'b1;
            add_random_token();
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (char_q.size() != 0 || in_valid)
            @(posedge clk);
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0 && decoded_q.size() == 0)
            $display("** escape_sequence_decoder: PASSED **");
        else
            $display("** escape_sequence_decoder: FAILED **");
        $finish;
    end

endmodule
